// File: rtl/core/gscd_pkg.sv
// Shared widths, codes and item types of the gradient stripe center detector.
`default_nettype none

package gscd_pkg;

	// Field widths
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned SUM_W    = 10;
	localparam int unsigned GRAD_W   = 11;
	localparam int unsigned ROW_W    = 12;
	localparam int unsigned IDX_W    = 12;
	localparam int unsigned CENTER_W = 13;
	localparam int unsigned SCORE_W  = 11;
	localparam int unsigned WIDTH_W  = 12;

	// Stream and configuration port widths
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned CFG_DATA_W = 12;

	// Default row length limit
	localparam int unsigned DEF_MAX_COLUMNS = 4096;

	// Threshold values after reset
	localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RESET = 11'd200;
	localparam logic [WIDTH_W-1:0] WIDTH_THRESHOLD_RESET = 12'd100;

	// Configuration register indexes
	typedef enum logic {
		CFG_SCORE_THRESHOLD = 1'b0,
		CFG_WIDTH_THRESHOLD = 1'b1
	} cfg_index_t;

	// One registered input column
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [ROW_W-1:0] row;
		logic             last;
	} column_t;

	// Row tracking state after the current column, handed to the result stage
	typedef struct packed {
		logic                     seen;
		logic [SUM_W-1:0]         peak_value;
		logic signed [GRAD_W-1:0] valley_value;
		logic [IDX_W-1:0]         peak_index;
		logic [IDX_W-1:0]         valley_index;
		logic [ROW_W-1:0]         row;
	} summary_t;

endpackage

`default_nettype wire

// File: rtl/core/gradient_stripe_center_detector_core.sv
// Top level of the gradient stripe center detector.
//
//  port group  dir  handshake           contents
//  s_*         in   s_tvalid/s_tready   one pixel column, tlast ends the row
//  m_*         out  m_tvalid/m_tready   one row result, tuser = stripe found
//  cfg_*       in   cfg_valid/cfg_ready threshold register write
//
// One column item is accepted every clock unless a last column is held in the
// input register by a stalled result; earlier columns keep flowing. A row
// result passes the input register, then the result register, after its last
// column is accepted. The row state update is a loop on the registered column.
// Reset clears the row state and the valid bits and loads the reset thresholds.
`default_nettype none

module gradient_stripe_center_detector_core #(
	parameter int unsigned MAX_COLUMNS = gscd_pkg::DEF_MAX_COLUMNS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// pixel_above [7:0], pixel_center [15:8], pixel_below [23:16],
	// row_position [35:24], zero pad [39:36]
	input  wire logic [gscd_pkg::IN_DATA_W-1:0]  s_tdata,
	// last_column
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// center_twice [12:0], row_out [24:13], stripe_score [35:25],
	// stripe_width [47:36]
	output logic [gscd_pkg::OUT_DATA_W-1:0]      m_tdata,
	// stripe_found
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire gscd_pkg::cfg_index_t            cfg_index,
	input  wire logic [gscd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gscd_pkg::*;

	logic     col_valid;
	column_t  col;
	logic     advance;
	logic     push;
	logic     out_free;
	summary_t summary;

	gscd_column_stage u_column_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.advance   (advance),
		.col_valid (col_valid),
		.col       (col)
	);

	gscd_tracker #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.col       (col),
		.out_free  (out_free),
		.advance   (advance),
		.push      (push),
		.summary   (summary)
	);

	gscd_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.summary   (summary),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

// File: rtl/core/gscd_column_stage.sv
// Input register: accepts one pixel column item and stores its column sum.
`default_nettype none

module gscd_column_stage (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// pixel_above [7:0], pixel_center [15:8], pixel_below [23:16],
	// row_position [35:24], zero pad [39:36]
	input  wire logic [gscd_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic                           s_tlast,
	input  wire logic                           advance,
	output logic                                col_valid,
	output gscd_pkg::column_t                   col
);
	import gscd_pkg::*;

	logic    valid_s1;
	column_t col_s1;
	logic    load;
	logic [SUM_W-1:0] sum;

	// Take a new item whenever the stage is empty or moving on this cycle
	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	// Sum the three stacked pixels
	assign sum = SUM_W'(s_tdata[PIX_W-1:0])
	           + SUM_W'(s_tdata[2*PIX_W-1:PIX_W])
	           + SUM_W'(s_tdata[3*PIX_W-1:2*PIX_W]);

	// Hold or advance the stage valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (load) begin
			col_s1.sum  <= sum;
			col_s1.row  <= s_tdata[3*PIX_W+ROW_W-1:3*PIX_W];
			col_s1.last <= s_tlast;
		end
	end

	assign col_valid = valid_s1;
	assign col       = col_s1;

endmodule

`default_nettype wire

// File: rtl/core/gscd_tracker.sv
// Row state: gradient of each interior column, peak and valley tracking.
`default_nettype none

module gscd_tracker #(
	parameter int unsigned MAX_COLUMNS = gscd_pkg::DEF_MAX_COLUMNS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               col_valid,
	input  wire gscd_pkg::column_t  col,
	input  wire logic               out_free,
	output logic                    advance,
	output logic                    push,
	output gscd_pkg::summary_t      summary
);
	import gscd_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_COLUMNS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_COLUMNS - 1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [SUM_W-1:0]         older_sum_q;
	logic [SUM_W-1:0]         newer_sum_q;
	logic [CNT_W-1:0]         count_q;
	logic [SUM_W-1:0]         peak_value_q;
	logic signed [GRAD_W-1:0] valley_value_q;
	logic [IDX_W-1:0]         peak_index_q;
	logic [IDX_W-1:0]         valley_index_q;
	logic                     seen_q;

	logic signed [GRAD_W-1:0] grad;
	logic signed [GRAD_W-1:0] peak_ext;
	logic [IDX_W-1:0]         where_idx;
	logic                     have_grad;
	logic                     valley_hit;
	logic                     peak_hit;

	logic [SUM_W-1:0]         peak_value_d;
	logic signed [GRAD_W-1:0] valley_value_d;
	logic [IDX_W-1:0]         peak_index_d;
	logic [IDX_W-1:0]         valley_index_d;
	logic                     seen_d;

	// Move on unless a row end waits for a busy result register
	assign advance = col_valid && (!col.last || out_free);
	assign push    = advance && col.last;

	// Gradient of the middle column: newest sum minus the one two back
	assign grad      = $signed({1'b0, col.sum}) - $signed({1'b0, older_sum_q});
	assign peak_ext  = $signed({1'b0, peak_value_q});
	assign where_idx = IDX_W'(count_q - CNT_ONE);
	assign have_grad = count_q >= CNT_TWO;

	assign valley_hit = have_grad && (grad < valley_value_q) && (peak_value_q != '0);
	assign peak_hit   = have_grad && (grad > peak_ext);

	// Update peak and valley; a new peak drops the valley found so far
	always_comb begin
		peak_value_d   = peak_value_q;
		valley_value_d = valley_value_q;
		peak_index_d   = peak_index_q;
		valley_index_d = valley_index_q;
		seen_d         = seen_q;
		if (valley_hit) begin
			valley_value_d = grad;
			valley_index_d = where_idx;
			seen_d         = 1'b1;
		end
		if (peak_hit) begin
			peak_value_d   = grad[SUM_W-1:0];
			peak_index_d   = where_idx;
			valley_value_d = '0;
			seen_d         = 1'b0;
		end
	end

	// Row state including the current column, for the result stage
	always_comb begin
		summary.seen         = seen_d;
		summary.peak_value   = peak_value_d;
		summary.valley_value = valley_value_d;
		summary.peak_index   = peak_index_d;
		summary.valley_index = valley_index_d;
		summary.row          = col.row;
	end

	// Advance the row state; clear it after the last column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_sum_q    <= '0;
			newer_sum_q    <= '0;
			count_q        <= '0;
			peak_value_q   <= '0;
			valley_value_q <= '0;
			peak_index_q   <= '0;
			valley_index_q <= '0;
			seen_q         <= 1'b0;
		end else if (advance) begin
			if (col.last) begin
				older_sum_q    <= '0;
				newer_sum_q    <= '0;
				count_q        <= '0;
				peak_value_q   <= '0;
				valley_value_q <= '0;
				peak_index_q   <= '0;
				valley_index_q <= '0;
				seen_q         <= 1'b0;
			end else begin
				older_sum_q    <= newer_sum_q;
				newer_sum_q    <= col.sum;
				count_q        <= (count_q == CNT_LAST) ? count_q : count_q + CNT_ONE;
				peak_value_q   <= peak_value_d;
				valley_value_q <= valley_value_d;
				peak_index_q   <= peak_index_d;
				valley_index_q <= valley_index_d;
				seen_q         <= seen_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// A valley is only recorded as a negative gradient after a nonzero peak
	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (valley_value_q < 0) && (peak_value_q != '0))
		else $error("valley flag set without negative valley after peak");

	// Row state is cleared after a row end
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (count_q == '0) && !seen_q && (peak_value_q == '0))
		else $error("row state not cleared after last column");
`endif

endmodule

`default_nettype wire

// File: rtl/core/gscd_result.sv
// Threshold registers and the result register of each row.
`default_nettype none

module gscd_result (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire gscd_pkg::cfg_index_t            cfg_index,
	input  wire logic [gscd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            push,
	input  wire gscd_pkg::summary_t              summary,
	output logic                                 out_free,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [gscd_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tuser
);
	import gscd_pkg::*;

	logic [SCORE_W-1:0]    score_th_q;
	logic [WIDTH_W-1:0]    width_th_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_found_q;

	logic [GRAD_W-1:0]     valley_mag;
	logic [SCORE_W-1:0]    score;
	logic [WIDTH_W-1:0]    span;
	logic [CENTER_W-1:0]   center_sum;
	logic [WIDTH_W-1:0]    width_res;
	logic [CENTER_W-1:0]   center_res;
	logic                  found;

	// Threshold registers, writable at any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_th_q <= SCORE_THRESHOLD_RESET;
			width_th_q <= WIDTH_THRESHOLD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCORE_THRESHOLD: score_th_q <= cfg_data[SCORE_W-1:0];
				CFG_WIDTH_THRESHOLD: width_th_q <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Score, width, center and the stripe decision
	assign valley_mag = GRAD_W'(-summary.valley_value);
	assign score      = SCORE_W'(summary.peak_value) + valley_mag;
	assign span       = summary.valley_index - summary.peak_index;
	assign center_sum = CENTER_W'(summary.peak_index) + CENTER_W'(summary.valley_index);
	assign width_res  = summary.seen ? span : '0;
	assign center_res = summary.seen ? center_sum : '0;
	assign found      = summary.seen && (score > score_th_q) && (span < width_th_q);

	assign out_free = !out_valid_q || m_tready;

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q  <= {width_res, score, summary.row, center_res};
			out_found_q <= found;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_found_q;

`ifndef NO_ASSERTIONS
	// A new result never lands on one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result overwritten while stalled");

	// A found stripe always has a center; the width may be zero once the
	// column count has saturated
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_found_q) |->
			(out_data_q[CENTER_W-1:0] != '0))
		else $error("found stripe with zero center");
`endif

endmodule

`default_nettype wire
